@@ rtl/dts_pkg.sv @@
// Package for the deadline task scheduler: sizes, operation/result/slot codes,
// controller states and the count saturation helper.
// No dependencies.
package dts_pkg;

  // Number of task slots
  localparam int NUM_TASKS = 8;
  localparam int ID_W      = $clog2(NUM_TASKS);
  localparam int CNT_W     = $clog2(NUM_TASKS + 1);

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int TID_W     = 3;
  localparam int TIME_W    = 32;
  localparam int KIND_W    = 2;
  localparam int PRIO_W    = 3;
  localparam int CNT_OUT_W = 4;
  localparam int CNT_SAT   = 15;

  typedef enum logic [OP_W-1:0] {
    OP_RELEASE  = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_QUERY    = 2'd2,
    OP_RSVD     = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRIO   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_COUNTS = 2'd2,
    KIND_IGNORE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SLOT_IDLE   = 2'd0,
    SLOT_ACTIVE = 2'd1,
    SLOT_ONTIME = 2'd2,
    SLOT_LATE   = 2'd3
  } slot_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_RESP,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // Clamp a slot count to the 4-bit output field
  function automatic logic [CNT_OUT_W-1:0] sat_count(logic [CNT_W-1:0] c);
    logic [CNT_W+CNT_OUT_W-1:0] w;
    w = {{CNT_OUT_W{1'b0}}, c};
    return (w > (CNT_W+CNT_OUT_W)'(CNT_SAT)) ? CNT_OUT_W'(CNT_SAT) : w[CNT_OUT_W-1:0];
  endfunction

endpackage

@@ rtl/dts_req_if.sv @@
// Request channel of the deadline task scheduler: valid/ready plus request fields.
// Depends on dts_pkg.
interface dts_req_if;
  logic                          valid;
  logic                          ready;
  logic [dts_pkg::OP_W-1:0]      operation;
  logic [dts_pkg::TID_W-1:0]     task_id;
  logic [dts_pkg::TIME_W-1:0]    event_time;
  logic [dts_pkg::TIME_W-1:0]    relative_deadline;

  modport source (
    output valid, operation, task_id, event_time, relative_deadline,
    input  ready
  );
  modport sink (
    input  valid, operation, task_id, event_time, relative_deadline,
    output ready
  );
endinterface

@@ rtl/dts_rsp_if.sv @@
// Result channel of the deadline task scheduler: valid/ready plus result fields.
// Depends on dts_pkg.
interface dts_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [dts_pkg::KIND_W-1:0]       kind;
  logic [dts_pkg::TID_W-1:0]        entry_task;
  logic [dts_pkg::PRIO_W-1:0]       priority_res;
  logic                             late;
  logic [dts_pkg::CNT_OUT_W-1:0]    busy_count;
  logic [dts_pkg::CNT_OUT_W-1:0]    missed_count;
  logic [dts_pkg::CNT_OUT_W-1:0]    done_count;
  logic                             last;

  modport source (
    output valid, kind, entry_task, priority_res, late,
           busy_count, missed_count, done_count, last,
    input  ready
  );
  modport sink (
    input  valid, kind, entry_task, priority_res, late,
           busy_count, missed_count, done_count, last,
    output ready
  );
endinterface

@@ rtl/dts_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dts_ram #(
  parameter  int Width = 32,
  parameter  int Depth = 8,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/deadline_task_scheduler.sv @@
// Deadline task scheduler: earliest-deadline-first slot table, deadlines in a RAM.
// Query or ignored request: the result is loaded from the response state, then the
// next request is taken. Completion: a deadline RAM read and the compare come first.
// Release with n active tasks: one selection pass over all NUM_TASKS slots per result;
// next request is taken after the last result. A stalled output holds the pass.
// Reset clears slot states, counters and control; deadline RAM is not cleared.
module deadline_task_scheduler (
  input logic      clk_i,
  input logic      rst_ni,
  dts_req_if.sink  req_i,
  dts_rsp_if.source rsp_o
);

  localparam int NTasks = dts_pkg::NUM_TASKS;
  localparam int IdW    = dts_pkg::ID_W;
  localparam int CntW   = dts_pkg::CNT_W;
  localparam int TimeW  = dts_pkg::TIME_W;
  localparam int TidW   = dts_pkg::TID_W;
  localparam int PrioW  = dts_pkg::PRIO_W;
  localparam int OutW   = dts_pkg::CNT_OUT_W;
  localparam int SumW   = CntW + 2;
  localparam logic [IdW-1:0] LastSlot = IdW'(NTasks - 1);

  dts_pkg::state_e state_q, state_d;
  dts_pkg::slot_e  status_q [NTasks];
  dts_pkg::slot_e  status_d [NTasks];

  logic [CntW-1:0]   act_q, act_d, ovd_q, ovd_d, ontime_q, ontime_d;
  logic [NTasks-1:0] pending_q, pending_d;

  // Latched request
  logic [TidW-1:0]   tid_q, tid_d;
  logic [IdW-1:0]    slot_q, slot_d;
  logic [TimeW-1:0]  time_q, time_d;
  dts_pkg::kind_e    kind_q, kind_d;
  logic              late_flag_q, late_flag_d;

  // Selection pass
  logic [IdW-1:0]    addr_q, addr_d;
  logic              iss_done_q, iss_done_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IdW-1:0]    rd_idx_q, rd_idx_d;
  logic              have_q, have_d;
  logic [IdW-1:0]    best_q, best_d;
  logic [TimeW-1:0]  best_dl_q, best_dl_d;
  logic [IdW-1:0]    rank_q, rank_d;

  // Output register
  logic              rsp_vld_q, rsp_vld_d;
  logic              rsp_load;
  dts_pkg::kind_e    rsp_kind_q, rsp_kind_d;
  logic [TidW-1:0]   rsp_task_q, rsp_task_d;
  logic [PrioW-1:0]  rsp_prio_q, rsp_prio_d;
  logic              rsp_late_q, rsp_late_d;
  logic              rsp_last_q, rsp_last_d;
  logic [OutW-1:0]   rsp_act_q, rsp_ovd_q, rsp_done_q;

  // RAM ports
  logic              ram_we;
  logic [IdW-1:0]    ram_raddr;
  logic [TimeW-1:0]  ram_wdata, ram_rdata;

  // Request decode
  logic              req_fire, id_ok, rel_go, cmp_go, out_free, last_rank, cand, is_late;
  logic [IdW-1:0]    in_slot;
  dts_pkg::slot_e    cur_st;

  assign req_fire  = req_i.valid && req_i.ready;
  assign in_slot   = IdW'(req_i.task_id);
  assign id_ok     = 32'(req_i.task_id) < 32'(NTasks);
  assign cur_st    = status_q[in_slot];
  assign rel_go    = (req_i.operation == dts_pkg::OP_RELEASE) && id_ok &&
                     (cur_st != dts_pkg::SLOT_ACTIVE);
  assign cmp_go    = (req_i.operation == dts_pkg::OP_COMPLETE) && id_ok &&
                     (cur_st == dts_pkg::SLOT_ACTIVE);
  assign out_free  = !rsp_vld_q || rsp_o.ready;
  assign last_rank = (CntW'(rank_q) + CntW'(1)) == act_q;
  assign cand      = rd_vld_q && pending_q[rd_idx_q] && (!have_q || (ram_rdata < best_dl_q));
  assign is_late   = time_q > ram_rdata;

  assign ram_wdata = req_i.event_time + req_i.relative_deadline;
  assign ram_raddr = (state_q == dts_pkg::ST_SCAN) ? addr_q : in_slot;

  // Deadline store
  dts_ram #(
    .Width (TimeW),
    .Depth (NTasks)
  ) u_deadline_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_slot),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dts_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (rel_go) begin
            state_d = dts_pkg::ST_SCAN;
          end else if (cmp_go) begin
            state_d = dts_pkg::ST_CMP;
          end else begin
            state_d = dts_pkg::ST_RESP;
          end
        end
      end
      dts_pkg::ST_CMP:  state_d = dts_pkg::ST_RESP;
      dts_pkg::ST_RESP: begin
        if (out_free) state_d = dts_pkg::ST_IDLE;
      end
      dts_pkg::ST_SCAN: begin
        if (rd_vld_q && (rd_idx_q == LastSlot)) state_d = dts_pkg::ST_EMIT;
      end
      dts_pkg::ST_EMIT: begin
        if (out_free) state_d = last_rank ? dts_pkg::ST_IDLE : dts_pkg::ST_SCAN;
      end
      default: state_d = dts_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    status_d    = status_q;
    act_d       = act_q;
    ovd_d       = ovd_q;
    ontime_d    = ontime_q;
    pending_d   = pending_q;
    tid_d       = tid_q;
    slot_d      = slot_q;
    time_d      = time_q;
    kind_d      = kind_q;
    late_flag_d = late_flag_q;
    addr_d      = addr_q;
    iss_done_d  = iss_done_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    have_d      = have_q;
    best_d      = best_q;
    best_dl_d   = best_dl_q;
    rank_d      = rank_q;
    ram_we      = 1'b0;
    rsp_load    = 1'b0;
    rsp_kind_d  = rsp_kind_q;
    rsp_task_d  = rsp_task_q;
    rsp_prio_d  = rsp_prio_q;
    rsp_late_d  = rsp_late_q;
    rsp_last_d  = rsp_last_q;

    unique case (state_q)
      dts_pkg::ST_IDLE: begin
        if (req_fire) begin
          tid_d       = req_i.task_id;
          slot_d      = in_slot;
          time_d      = req_i.event_time;
          late_flag_d = 1'b0;
          kind_d      = dts_pkg::KIND_IGNORE;
          if (req_i.operation == dts_pkg::OP_QUERY) begin
            kind_d = dts_pkg::KIND_COUNTS;
            tid_d  = '0;
          end
          if (rel_go) begin
            // New deadline in, slot becomes active, snapshot active set
            ram_we            = 1'b1;
            status_d[in_slot] = dts_pkg::SLOT_ACTIVE;
            act_d             = act_q + CntW'(1);
            if (cur_st == dts_pkg::SLOT_ONTIME) ontime_d = ontime_q - CntW'(1);
            if (cur_st == dts_pkg::SLOT_LATE)   ovd_d    = ovd_q - CntW'(1);
            for (int i = 0; i < NTasks; i++) begin
              pending_d[i] = (status_q[i] == dts_pkg::SLOT_ACTIVE) || (IdW'(i) == in_slot);
            end
            rank_d     = '0;
            addr_d     = '0;
            iss_done_d = 1'b0;
            have_d     = 1'b0;
          end
        end
      end
      dts_pkg::ST_CMP: begin
        // Deadline read data valid: mark done on time or late
        status_d[slot_q] = is_late ? dts_pkg::SLOT_LATE : dts_pkg::SLOT_ONTIME;
        act_d            = act_q - CntW'(1);
        if (is_late) ovd_d = ovd_q + CntW'(1);
        else         ontime_d = ontime_q + CntW'(1);
        kind_d      = dts_pkg::KIND_DONE;
        late_flag_d = is_late;
      end
      dts_pkg::ST_RESP: begin
        if (out_free) begin
          rsp_load   = 1'b1;
          rsp_kind_d = kind_q;
          rsp_task_d = tid_q;
          rsp_prio_d = '0;
          rsp_late_d = late_flag_q;
          rsp_last_d = 1'b1;
        end
      end
      dts_pkg::ST_SCAN: begin
        // Issue one read per cycle, compare its data in the following cycle
        if (!iss_done_q) begin
          addr_d     = addr_q + IdW'(1);
          iss_done_d = (addr_q == LastSlot);
          rd_vld_d   = 1'b1;
          rd_idx_d   = addr_q;
        end
        if (cand) begin
          have_d    = 1'b1;
          best_d    = rd_idx_q;
          best_dl_d = ram_rdata;
        end
      end
      dts_pkg::ST_EMIT: begin
        if (out_free) begin
          rsp_load          = 1'b1;
          rsp_kind_d        = dts_pkg::KIND_PRIO;
          rsp_task_d        = TidW'(best_q);
          rsp_prio_d        = PrioW'(LastSlot - rank_q);
          rsp_late_d        = 1'b0;
          rsp_last_d        = last_rank;
          pending_d[best_q] = 1'b0;
          rank_d            = rank_q + IdW'(1);
          addr_d            = '0;
          iss_done_d        = 1'b0;
          have_d            = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign rsp_vld_d = rsp_load ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_vld_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dts_pkg::ST_IDLE;
      for (int i = 0; i < NTasks; i++) begin
        status_q[i] <= dts_pkg::SLOT_IDLE;
      end
      act_q      <= '0;
      ovd_q      <= '0;
      ontime_q   <= '0;
      pending_q  <= '0;
      iss_done_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      have_q     <= 1'b0;
      rank_q     <= '0;
      rsp_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      status_q   <= status_d;
      act_q      <= act_d;
      ovd_q      <= ovd_d;
      ontime_q   <= ontime_d;
      pending_q  <= pending_d;
      iss_done_q <= iss_done_d;
      rd_vld_q   <= rd_vld_d;
      have_q     <= have_d;
      rank_q     <= rank_d;
      rsp_vld_q  <= rsp_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tid_q       <= tid_d;
    slot_q      <= slot_d;
    time_q      <= time_d;
    kind_q      <= kind_d;
    late_flag_q <= late_flag_d;
    addr_q      <= addr_d;
    rd_idx_q    <= rd_idx_d;
    best_q      <= best_d;
    best_dl_q   <= best_dl_d;
    rsp_kind_q  <= rsp_kind_d;
    rsp_task_q  <= rsp_task_d;
    rsp_prio_q  <= rsp_prio_d;
    rsp_late_q  <= rsp_late_d;
    rsp_last_q  <= rsp_last_d;
    if (rsp_load) begin
      rsp_act_q  <= dts_pkg::sat_count(act_q);
      rsp_ovd_q  <= dts_pkg::sat_count(ovd_q);
      rsp_done_q <= dts_pkg::sat_count(ontime_q);
    end
  end

  // Ports
  assign req_i.ready         = (state_q == dts_pkg::ST_IDLE);
  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.kind          = rsp_kind_q;
  assign rsp_o.entry_task    = rsp_task_q;
  assign rsp_o.priority_res  = rsp_prio_q;
  assign rsp_o.late          = rsp_late_q;
  assign rsp_o.busy_count    = rsp_act_q;
  assign rsp_o.missed_count  = rsp_ovd_q;
  assign rsp_o.done_count    = rsp_done_q;
  assign rsp_o.last          = rsp_last_q;

  // Assertions
  a_cnt_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SumW'(act_q) + SumW'(ovd_q) + SumW'(ontime_q)) <= SumW'(NTasks))
    else $error("slot counters exceed slot count");

  a_pass_has_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dts_pkg::ST_SCAN || state_q == dts_pkg::ST_EMIT) |-> (act_q != '0))
    else $error("selection pass with no active task");

  a_emit_has_winner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dts_pkg::ST_EMIT) |-> have_q)
    else $error("selection pass ended without a winner");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |-> (!rsp_vld_q || rsp_o.ready))
    else $error("result register overwritten before transfer");

endmodule
